FILE: hdl/dmlc_pkg.sv
`timescale 1ns / 1ps

package dmlc_pkg;

    localparam int unsigned SEEN_W     = 18;
    localparam int unsigned MID_DEPTH  = 2;
    localparam int unsigned OUT_DEPTH  = 2;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [SEEN_W-1:0] BIT_HEADER   = SEEN_W'(1) << 0;
    localparam logic [SEEN_W-1:0] BIT_MAP_LIST = SEEN_W'(1) << 7;
    localparam int unsigned       ID_BIT_LO    = 1;
    localparam logic [15:0]       LAST_ID_TYPE = 16'h0006;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILE_SIZE   = 2'd0,
        CFG_DATA_SIZE   = 2'd1,
        CFG_DECLARED_ID = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_ORDER       = 4'd1,
        ST_PAST_END    = 4'd2,
        ST_TOO_MANY    = 4'd3,
        ST_UNKNOWN     = 4'd4,
        ST_DUPLICATE   = 4'd5,
        ST_MISS_HEADER = 4'd6,
        ST_MISS_MAP    = 4'd7,
        ST_MISS_STRING = 4'd8,
        ST_MISS_TYPE   = 4'd9,
        ST_MISS_PROTO  = 4'd10,
        ST_MISS_FIELD  = 4'd11,
        ST_MISS_METHOD = 4'd12,
        ST_MISS_CLASS  = 4'd13
    } status_t;

    typedef struct packed {
        logic [15:0] entry_type;
        logic [31:0] entry_offset;
        logic [31:0] entry_count;
        logic        is_last;
    } entry_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        is_final;
        logic [31:0] data_item_count;
    } result_t;

    typedef struct packed {
        logic [31:0]       offset;
        logic [31:0]       count;
        logic [SEEN_W-1:0] type_bit;
        logic              is_data;
        logic              is_last;
    } work_t;

    function automatic logic [SEEN_W-1:0] type_bit(input logic [15:0] t);
        logic [SEEN_W-1:0] bit_v;
        bit_v = '0;
        if (t <= LAST_ID_TYPE)
        begin
            bit_v = SEEN_W'(1) << t[2:0];
        end
        else if (t >= 16'h1000 && t <= 16'h1003)
        begin
            bit_v = SEEN_W'(1) << (5'd7 + 5'(t[1:0]));
        end
        else if (t >= 16'h2000 && t <= 16'h2006)
        begin
            bit_v = SEEN_W'(1) << (5'd11 + 5'(t[2:0]));
        end
        return bit_v;
    endfunction

endpackage

FILE: hdl/dex_map_list_checker_core.sv
`timescale 1ns / 1ps
// An accepted entry is registered in the mid queue, its result in the out queue.
// Throughput: one entry per cycle unless full; back stage likewise unless res_full.
// Entries pass through a MID_DEPTH queue, results through an OUT_DEPTH queue.
// Reset (rst_n, async, active low) empties both queues, clears list state and
// sets file_size, data_size and declared_id_sections to zero.

module dex_map_list_checker_core #(
    parameter int unsigned MID_DEPTH = dmlc_pkg::MID_DEPTH,
    parameter int unsigned OUT_DEPTH = dmlc_pkg::OUT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  dmlc_pkg::entry_t               entry,
    output logic                           empty,
    input  logic                           pop,
    output dmlc_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    dmlc_pkg::work_t   work_in;
    dmlc_pkg::work_t   work_out;
    dmlc_pkg::result_t res;
    logic              work_empty;
    logic              work_pop;
    logic              res_full;
    logic              res_push;

    dmlc_front u_front (
        .entry (entry),
        .work  (work_in)
    );

    dmlc_fifo #(
        .T     (dmlc_pkg::work_t),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (work_in),
        .pop     (work_pop),
        .empty   (work_empty),
        .rd_data (work_out)
    );

    dmlc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .work_empty (work_empty),
        .work       (work_out),
        .work_pop   (work_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    dmlc_fifo #(
        .T     (dmlc_pkg::result_t),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (result)
    );

endmodule

FILE: hdl/dmlc_fifo.sv
`timescale 1ns / 1ps

module dmlc_fifo #(
    parameter type         T     = logic,
    parameter int unsigned DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     wr_data,
    input  logic pop,
    output logic empty,
    output T     rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/dmlc_front.sv
`timescale 1ns / 1ps

module dmlc_front (
    input  dmlc_pkg::entry_t entry,
    output dmlc_pkg::work_t  work
);

    always_comb
    begin
        work.offset   = entry.entry_offset;
        work.count    = entry.entry_count;
        work.type_bit = dmlc_pkg::type_bit(entry.entry_type);
        work.is_data  = (entry.entry_type > dmlc_pkg::LAST_ID_TYPE);
        work.is_last  = entry.is_last;
    end

endmodule

FILE: hdl/dmlc_back.sv
`timescale 1ns / 1ps

module dmlc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmlc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              work_empty,
    input  dmlc_pkg::work_t                   work,
    output logic                              work_pop,
    input  logic                              res_full,
    output logic                              res_push,
    output dmlc_pkg::result_t                 res
);

    localparam int unsigned SW = dmlc_pkg::SEEN_W;

    logic [31:0]       file_size_reg;
    logic [31:0]       data_size_reg;
    logic [5:0]        declared_reg;

    logic              seen_first_reg;
    logic              seen_first_next;
    logic [31:0]       prev_offset_reg;
    logic [31:0]       prev_offset_next;
    logic [31:0]       left_reg;
    logic [31:0]       left_next;
    logic [31:0]       total_reg;
    logic [31:0]       total_next;
    logic [SW-1:0]     sections_reg;
    logic [SW-1:0]     sections_next;
    dmlc_pkg::status_t sticky_reg;
    dmlc_pkg::status_t sticky_next;

    logic              fire;

    assign cfg_ready = 1'b1;
    assign fire      = !work_empty && !res_full;
    assign work_pop  = fire;
    assign res_push  = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            data_size_reg <= '0;
            declared_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (dmlc_pkg::cfg_idx_t'(cfg_index))
                dmlc_pkg::CFG_FILE_SIZE:   file_size_reg <= cfg_data;
                dmlc_pkg::CFG_DATA_SIZE:   data_size_reg <= cfg_data;
                dmlc_pkg::CFG_DECLARED_ID: declared_reg  <= cfg_data[5:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        logic              first;
        logic [31:0]       left_eff;
        logic              bad_order;
        logic              bad_end;
        logic              bad_count;
        logic              charge;
        dmlc_pkg::status_t chk;
        dmlc_pkg::status_t verdict;
        logic [SW-1:0]     sections_upd;

        first            = !seen_first_reg;
        left_eff         = first ? data_size_reg : left_reg;
        bad_order        = !first && (prev_offset_reg >= work.offset);
        bad_end          = (work.offset >= file_size_reg);
        bad_count        = work.is_data && (work.count > left_eff);
        charge           = work.is_data && !bad_order && !bad_end && !bad_count;

        seen_first_next  = seen_first_reg;
        prev_offset_next = prev_offset_reg;
        left_next        = left_reg;
        total_next       = total_reg;
        sections_next    = sections_reg;
        sticky_next      = sticky_reg;
        chk              = dmlc_pkg::ST_OK;
        sections_upd     = sections_reg | work.type_bit;

        if (bad_order)
        begin
            chk = dmlc_pkg::ST_ORDER;
        end
        else if (bad_end)
        begin
            chk = dmlc_pkg::ST_PAST_END;
        end
        else if (bad_count)
        begin
            chk = dmlc_pkg::ST_TOO_MANY;
        end
        else if (work.type_bit == '0)
        begin
            chk = dmlc_pkg::ST_UNKNOWN;
        end
        else if ((sections_reg & work.type_bit) != '0)
        begin
            chk = dmlc_pkg::ST_DUPLICATE;
        end

        if (fire && sticky_reg == dmlc_pkg::ST_OK)
        begin
            if (!bad_order)
            begin
                seen_first_next = 1'b1;
                left_next       = left_eff;
            end
            if (charge)
            begin
                left_next  = left_eff - work.count;
                total_next = total_reg + work.count;
            end
            if (chk == dmlc_pkg::ST_OK)
            begin
                sections_next    = sections_upd;
                prev_offset_next = work.offset;
            end
            sticky_next = chk;
        end

        verdict = dmlc_pkg::ST_OK;
        if ((sections_next & dmlc_pkg::BIT_HEADER) == '0)
        begin
            verdict = dmlc_pkg::ST_MISS_HEADER;
        end
        else if ((sections_next & dmlc_pkg::BIT_MAP_LIST) == '0)
        begin
            verdict = dmlc_pkg::ST_MISS_MAP;
        end
        else if (declared_reg[0] && !sections_next[dmlc_pkg::ID_BIT_LO + 0])
        begin
            verdict = dmlc_pkg::ST_MISS_STRING;
        end
        else if (declared_reg[1] && !sections_next[dmlc_pkg::ID_BIT_LO + 1])
        begin
            verdict = dmlc_pkg::ST_MISS_TYPE;
        end
        else if (declared_reg[2] && !sections_next[dmlc_pkg::ID_BIT_LO + 2])
        begin
            verdict = dmlc_pkg::ST_MISS_PROTO;
        end
        else if (declared_reg[3] && !sections_next[dmlc_pkg::ID_BIT_LO + 3])
        begin
            verdict = dmlc_pkg::ST_MISS_FIELD;
        end
        else if (declared_reg[4] && !sections_next[dmlc_pkg::ID_BIT_LO + 4])
        begin
            verdict = dmlc_pkg::ST_MISS_METHOD;
        end
        else if (declared_reg[5] && !sections_next[dmlc_pkg::ID_BIT_LO + 5])
        begin
            verdict = dmlc_pkg::ST_MISS_CLASS;
        end

        if (fire && work.is_last && sticky_next == dmlc_pkg::ST_OK)
        begin
            sticky_next = verdict;
        end

        res.status          = 4'(sticky_next);
        res.is_final        = work.is_last;
        res.data_item_count = total_next;

        if (fire && work.is_last)
        begin
            seen_first_next  = 1'b0;
            prev_offset_next = '0;
            left_next        = '0;
            total_next       = '0;
            sections_next    = '0;
            sticky_next      = dmlc_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg  <= 1'b0;
            prev_offset_reg <= '0;
            left_reg        <= '0;
            total_reg       <= '0;
            sections_reg    <= '0;
            sticky_reg      <= dmlc_pkg::ST_OK;
        end
        else
        begin
            seen_first_reg  <= seen_first_next;
            prev_offset_reg <= prev_offset_next;
            left_reg        <= left_next;
            total_reg       <= total_next;
            sections_reg    <= sections_next;
            sticky_reg      <= sticky_next;
        end
    end

`ifndef SYNTH
    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
        else $error("result pushed into a full queue");

    a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        fire && work.is_last |=> !seen_first_reg && sticky_reg == dmlc_pkg::ST_OK
            && sections_reg == '0 && total_reg == '0)
        else $error("list state not cleared after last entry");

    a_sticky_holds : assert property (@(posedge clk) disable iff (!rst_n)
        sticky_reg != dmlc_pkg::ST_OK && !(fire && work.is_last)
            |=> $stable(sticky_reg) && $stable(total_reg) && $stable(sections_reg))
        else $error("state changed after sticky error");

    a_header_before_ok : assert property (@(posedge clk) disable iff (!rst_n)
        fire && work.is_last && res.status == 4'(dmlc_pkg::ST_OK)
            |-> (sections_reg | work.type_bit) != '0)
        else $error("ok verdict without any section");
`endif

endmodule
